FILE: rtl/itc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itc_pkg;

   localparam int NUM_COUNTERS = 3;
   localparam int CNT_W        = 16;

   // item actions
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   localparam logic [1:0] PORT_CTRL    = 2'd3;
   localparam logic [1:0] SEL_READBACK = 2'd3;

   // access modes
   localparam logic [1:0] ACC_LATCH = 2'd0;
   localparam logic [1:0] ACC_LSB   = 2'd1;
   localparam logic [1:0] ACC_MSB   = 2'd2;
   localparam logic [1:0] ACC_BOTH  = 2'd3;

   // counting modes
   localparam logic [2:0] MODE_TERMINAL = 3'd0;
   localparam logic [2:0] MODE_RATE     = 3'd2;
   localparam logic [2:0] MODE_SQUARE   = 3'd3;

   localparam logic [7:0] RDATA_IDLE = 8'hff;

   typedef struct packed {
      logic [7:0] rdata;
      logic       out_zero;
      logic       out_one;
      logic       out_two;
      logic       irq_pulse;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/itc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface itc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [1:0] port;
   logic [7:0] wdata;

   modport source (output valid, output action, output port, output wdata, input ready);
   modport sink   (input valid, input action, input port, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/itc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface itc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] rdata;
   logic       out_zero;
   logic       out_one;
   logic       out_two;
   logic       irq_pulse;

   modport source (output valid, output rdata, output out_zero, output out_one,
                   output out_two, output irq_pulse, input ready);
   modport sink   (input valid, input rdata, input out_zero, input out_one,
                   input out_two, input irq_pulse, output ready);
endinterface

`default_nettype wire

FILE: rtl/interval_timer_three_channel.sv
// Three-channel interval timer with a byte register interface.
// req_chan carries one word per item: a tick (advances every running
// counter by one step), a register read or a register write. Ports 0-2
// are counter data, port 3 takes control words and latch commands.
// rsp_chan returns exactly one word per request: the read byte (0xff
// when nothing is read), the three OUT levels after the item and the
// counter 0 interrupt pulse.
// The response word is registered; it goes to the response register when that
// is empty or being popped, else to the skid register. Throughput: one request
// per cycle while the skid register is empty; the counter state is updated at
// the accepting edge from combinational next-state logic.
// A two-word output buffer (response register plus skid register) takes
// the word of a request accepted while the receiver holds rsp ready low.
// req ready is low while the skid register is full, so requests resume
// once rsp ready returns high and the skid word moves to the response register.
// Reset (synchronous, active high): all counters stopped and cleared,
// mode 0, access mode LSB then MSB, OUT levels low, buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module interval_timer_three_channel (
   input  wire logic  clock,
   input  wire logic  reset,
   itc_req_if.sink    req_chan,
   itc_rsp_if.source  rsp_chan
);
   import itc_pkg::*;

   logic [CNT_W-1:0] count_ff    [NUM_COUNTERS];
   logic [CNT_W-1:0] count_in    [NUM_COUNTERS];
   logic [CNT_W-1:0] reload_ff   [NUM_COUNTERS];
   logic [CNT_W-1:0] reload_in   [NUM_COUNTERS];
   logic [CNT_W-1:0] latched_ff  [NUM_COUNTERS];
   logic [CNT_W-1:0] latched_in  [NUM_COUNTERS];
   logic [2:0]       mode_ff     [NUM_COUNTERS];
   logic [2:0]       mode_in     [NUM_COUNTERS];
   logic [1:0]       access_ff   [NUM_COUNTERS];
   logic [1:0]       access_in   [NUM_COUNTERS];
   logic [NUM_COUNTERS-1:0] latch_valid_ff, latch_valid_in;
   logic [NUM_COUNTERS-1:0] rd_high_ff, rd_high_in;
   logic [NUM_COUNTERS-1:0] wr_high_ff, wr_high_in;
   logic [NUM_COUNTERS-1:0] level_ff, level_in;
   logic [NUM_COUNTERS-1:0] counting_ff, counting_in;

   rsp_word_type rsp_word_ff, rsp_word_in, skid_word_ff, new_word;
   logic         rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;

   logic push, pop;

   assign req_chan.ready = !skid_valid_ff;
   assign push           = req_chan.valid && !skid_valid_ff;
   assign pop            = rsp_valid_ff && rsp_chan.ready;

   // counter state update and response word
   always_comb begin
      logic [CNT_W-1:0] dec1, dec2, src;
      logic [7:0]       ctl;
      logic [7:0]       rd;
      logic             ev0;
      logic [2:0]       levels;

      rd     = RDATA_IDLE;
      ev0    = 1'b0;
      levels = 3'b000;
      dec1   = '0;
      dec2   = '0;
      src    = '0;
      ctl    = req_chan.wdata;
      if (ctl[2]) begin
         ctl[3] = 1'b0;
      end

      for (int n = 0; n < NUM_COUNTERS; n++) begin
         count_in[n]       = count_ff[n];
         reload_in[n]      = reload_ff[n];
         latched_in[n]     = latched_ff[n];
         mode_in[n]        = mode_ff[n];
         access_in[n]      = access_ff[n];
         latch_valid_in[n] = latch_valid_ff[n];
         rd_high_in[n]     = rd_high_ff[n];
         wr_high_in[n]     = wr_high_ff[n];
         level_in[n]       = level_ff[n];
         counting_in[n]    = counting_ff[n];

         if (push) begin
            case (req_chan.action)
               ACT_TICK: begin
                  dec1 = count_ff[n] - CNT_W'(1);
                  dec2 = count_ff[n] - CNT_W'(2);
                  if (counting_ff[n]) begin
                     case (mode_ff[n])
                        MODE_TERMINAL: begin
                           if (count_ff[n] != '0) begin
                              count_in[n] = dec1;
                              if (dec1 == '0) begin
                                 level_in[n] = 1'b1;
                                 if (n == 0) ev0 = 1'b1;
                              end
                           end
                        end
                        MODE_RATE: begin
                           count_in[n] = dec1;
                           if (dec1 == CNT_W'(1)) begin
                              level_in[n] = 1'b0;
                           end else if (dec1 == '0) begin
                              level_in[n] = 1'b1;
                              count_in[n] = reload_ff[n];
                              if (n == 0) ev0 = 1'b1;
                           end
                        end
                        MODE_SQUARE: begin
                           count_in[n] = dec2;
                           if (level_ff[n]) begin
                              // high half ends at 0, or at all-ones for odd reloads
                              if (dec2 == '0 || dec2 == '1) begin
                                 level_in[n] = 1'b0;
                                 count_in[n] = reload_ff[n];
                              end
                           end else if (dec2 == '0 || dec2 == CNT_W'(1)) begin
                              level_in[n] = 1'b1;
                              count_in[n] = reload_ff[n];
                              if (n == 0) ev0 = 1'b1;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
               ACT_READ: begin
                  if (req_chan.port == 2'(n)) begin
                     src = latch_valid_ff[n] ? latched_ff[n] : count_ff[n];
                     unique case (access_ff[n])
                        ACC_LSB: begin
                           rd                = src[7:0];
                           latch_valid_in[n] = 1'b0;
                        end
                        ACC_MSB: begin
                           rd                = src[15:8];
                           latch_valid_in[n] = 1'b0;
                        end
                        ACC_BOTH: begin
                           if (!rd_high_ff[n]) begin
                              rd            = src[7:0];
                              rd_high_in[n] = 1'b1;
                           end else begin
                              rd                = src[15:8];
                              rd_high_in[n]     = 1'b0;
                              latch_valid_in[n] = 1'b0;
                           end
                        end
                        default: rd = RDATA_IDLE;
                     endcase
                  end
               end
               ACT_WRITE: begin
                  if (req_chan.port == 2'(n)) begin
                     unique case (access_ff[n])
                        ACC_LSB: begin
                           count_in[n]    = {count_ff[n][15:8], req_chan.wdata};
                           reload_in[n]   = {count_ff[n][15:8], req_chan.wdata};
                           counting_in[n] = 1'b1;
                        end
                        ACC_MSB: begin
                           count_in[n]    = {req_chan.wdata, count_ff[n][7:0]};
                           reload_in[n]   = {req_chan.wdata, count_ff[n][7:0]};
                           counting_in[n] = 1'b1;
                        end
                        ACC_BOTH: begin
                           if (!wr_high_ff[n]) begin
                              reload_in[n]  = {count_ff[n][15:8], req_chan.wdata};
                              wr_high_in[n] = 1'b1;
                           end else begin
                              reload_in[n]   = {req_chan.wdata, reload_ff[n][7:0]};
                              count_in[n]    = {req_chan.wdata, reload_ff[n][7:0]};
                              wr_high_in[n]  = 1'b0;
                              counting_in[n] = 1'b1;
                           end
                        end
                        default: ;
                     endcase
                  end else if (req_chan.port == PORT_CTRL && ctl[7:6] != SEL_READBACK
                               && ctl[7:6] == 2'(n)) begin
                     if (ctl[5:4] == ACC_LATCH) begin
                        if (!latch_valid_ff[n]) begin
                           latch_valid_in[n] = 1'b1;
                           latched_in[n]     = count_ff[n];
                           rd_high_in[n]     = 1'b0;
                        end
                     end else begin
                        mode_in[n]    = ctl[3:1];
                        access_in[n]  = ctl[5:4];
                        wr_high_in[n] = 1'b0;
                        count_in[n]   = '0;
                     end
                  end
               end
               default: ;
            endcase
         end
         levels[n] = level_in[n];
      end

      new_word.rdata     = rd;
      new_word.out_zero  = levels[0];
      new_word.out_one   = levels[1];
      new_word.out_two   = levels[2];
      new_word.irq_pulse = ev0;
   end

   // two-word output buffer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            rsp_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            rsp_word_in = new_word;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff) begin
            rsp_word_in  = new_word;
            rsp_valid_in = 1'b1;
         end else begin
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_COUNTERS; n++) begin
            count_ff[n]   <= '0;
            reload_ff[n]  <= '0;
            latched_ff[n] <= '0;
            mode_ff[n]    <= MODE_TERMINAL;
            access_ff[n]  <= ACC_BOTH;
         end
         latch_valid_ff <= '0;
         rd_high_ff     <= '0;
         wr_high_ff     <= '0;
         level_ff       <= '0;
         counting_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         for (int n = 0; n < NUM_COUNTERS; n++) begin
            count_ff[n]   <= count_in[n];
            reload_ff[n]  <= reload_in[n];
            latched_ff[n] <= latched_in[n];
            mode_ff[n]    <= mode_in[n];
            access_ff[n]  <= access_in[n];
         end
         latch_valid_ff <= latch_valid_in;
         rd_high_ff     <= rd_high_in;
         wr_high_ff     <= wr_high_in;
         level_ff       <= level_in;
         counting_ff    <= counting_in;
         rsp_valid_ff   <= rsp_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (push && rsp_valid_ff && !pop) begin
         skid_word_ff <= new_word;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.rdata     = rsp_word_ff.rdata;
   assign rsp_chan.out_zero  = rsp_word_ff.out_zero;
   assign rsp_chan.out_one   = rsp_word_ff.out_one;
   assign rsp_chan.out_two   = rsp_word_ff.out_two;
   assign rsp_chan.irq_pulse = rsp_word_ff.irq_pulse;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held with empty response register");

   a_irq_with_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.irq_pulse |-> rsp_word_ff.out_zero)
      else $error("interrupt pulse without counter 0 output high");

   a_high_byte_mode: assert property (@(posedge clock) disable iff (reset)
      wr_high_ff[0] |-> access_ff[0] == ACC_BOTH)
      else $error("write byte pointer set outside LSB-then-MSB access");

   a_counting_sticky: assert property (@(posedge clock) disable iff (reset)
      counting_ff[0] |=> counting_ff[0])
      else $error("counter 0 stopped without reset");

endmodule

`default_nettype wire

FILE: tb/sv/tb_interval_timer_three_channel.sv
`timescale 1ns / 1ps

module tb_interval_timer_three_channel;
   import itc_pkg::*;

   localparam logic [1:0] ACT_NOP   = 2'd3;
   localparam int ITEM_TARGET       = 1050;
   localparam int STALL_LIMIT       = 4000;
   localparam int DRAIN_TAIL        = 8;

   logic clock = 1'b0;
   logic reset;

   always #1 clock = ~clock;

   itc_req_if req_chan();
   itc_rsp_if rsp_chan();

   interval_timer_three_channel i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow of the timer state
   logic [CNT_W-1:0] cnt_now       [NUM_COUNTERS];
   logic [CNT_W-1:0] cnt_reload    [NUM_COUNTERS];
   logic [CNT_W-1:0] cnt_latched   [NUM_COUNTERS];
   logic             latch_held    [NUM_COUNTERS];
   logic [2:0]       cnt_mode      [NUM_COUNTERS];
   logic [1:0]       acc_mode      [NUM_COUNTERS];
   logic             read_msb_next [NUM_COUNTERS];
   logic             write_msb_next[NUM_COUNTERS];
   logic             out_level     [NUM_COUNTERS];
   logic             cnt_running   [NUM_COUNTERS];

   rsp_word_type pending_rsp_words[$];
   rsp_word_type oldest_word;
   int           fail_count = 0;
   int           items_sent = 0;
   int           quiet_cycles = 0;
   bit           no_gaps = 1'b0;

   int unsigned  rsp_left = 0;
   bit           rsp_stall = 1'b0;
   int unsigned  rsp_pick;

   // ------------------------------------------------------------------
   // timer prediction
   // ------------------------------------------------------------------
   task automatic predict_timer_word(input logic [1:0] act, input logic [1:0] prt,
                                     input logic [7:0] data);
      rsp_word_type     w;
      logic [CNT_W-1:0] src;
      logic [7:0]       cw;
      logic [1:0]       sel;
      bit               fired;
      w.rdata     = RDATA_IDLE;
      w.irq_pulse = 1'b0;
      case (act)
         ACT_TICK: begin
            for (int n = 0; n < NUM_COUNTERS; n++) begin
               fired = 1'b0;
               if (cnt_running[n]) begin
                  case (cnt_mode[n])
                     MODE_TERMINAL: begin
                        if (cnt_now[n] != 0) begin
                           cnt_now[n] = cnt_now[n] - 1'b1;
                           if (cnt_now[n] == 0) begin
                              out_level[n] = 1'b1;
                              fired = 1'b1;
                           end
                        end
                     end
                     MODE_RATE: begin
                        cnt_now[n] = cnt_now[n] - 1'b1;
                        if (cnt_now[n] == 1) begin
                           out_level[n] = 1'b0;
                        end else if (cnt_now[n] == 0) begin
                           out_level[n] = 1'b1;
                           fired = 1'b1;
                           cnt_now[n] = cnt_reload[n];
                        end
                     end
                     MODE_SQUARE: begin
                        cnt_now[n] = cnt_now[n] - 2'd2;
                        if (out_level[n]) begin
                           if (cnt_now[n] == 0 || cnt_now[n] == 16'hffff) begin
                              out_level[n] = 1'b0;
                              cnt_now[n] = cnt_reload[n];
                           end
                        end else if (cnt_now[n] == 0 || cnt_now[n] == 1) begin
                           out_level[n] = 1'b1;
                           fired = 1'b1;
                           cnt_now[n] = cnt_reload[n];
                        end
                     end
                     default: ;
                  endcase
               end
               if (n == 0) w.irq_pulse = fired;
            end
         end
         ACT_READ: begin
            if (prt < NUM_COUNTERS) begin
               src = latch_held[prt] ? cnt_latched[prt] : cnt_now[prt];
               case (acc_mode[prt])
                  ACC_LSB: begin
                     latch_held[prt] = 1'b0;
                     w.rdata = src[7:0];
                  end
                  ACC_MSB: begin
                     latch_held[prt] = 1'b0;
                     w.rdata = src[15:8];
                  end
                  ACC_BOTH: begin
                     if (!read_msb_next[prt]) begin
                        read_msb_next[prt] = 1'b1;
                        w.rdata = src[7:0];
                     end else begin
                        read_msb_next[prt] = 1'b0;
                        latch_held[prt] = 1'b0;
                        w.rdata = src[15:8];
                     end
                  end
                  default: ;
               endcase
            end
         end
         ACT_WRITE: begin
            if (prt == PORT_CTRL) begin
               sel = data[7:6];
               if (sel != SEL_READBACK && sel < NUM_COUNTERS) begin
                  if (data[5:4] == ACC_LATCH) begin
                     if (!latch_held[sel]) begin
                        latch_held[sel] = 1'b1;
                        cnt_latched[sel] = cnt_now[sel];
                        read_msb_next[sel] = 1'b0;
                     end
                  end else begin
                     cw = data;
                     if (cw[2]) cw[3] = 1'b0;   // modes 6/7 alias to 2/3
                     cnt_mode[sel] = cw[3:1];
                     acc_mode[sel] = cw[5:4];
                     write_msb_next[sel] = 1'b0;
                     cnt_now[sel] = '0;
                  end
               end
            end else if (prt < NUM_COUNTERS) begin
               case (acc_mode[prt])
                  ACC_LSB: begin
                     cnt_now[prt][7:0] = data;
                     cnt_reload[prt] = cnt_now[prt];
                     cnt_running[prt] = 1'b1;
                  end
                  ACC_MSB: begin
                     cnt_now[prt][15:8] = data;
                     cnt_reload[prt] = cnt_now[prt];
                     cnt_running[prt] = 1'b1;
                  end
                  ACC_BOTH: begin
                     if (!write_msb_next[prt]) begin
                        cnt_reload[prt] = {cnt_now[prt][15:8], data};
                        write_msb_next[prt] = 1'b1;
                     end else begin
                        cnt_reload[prt][15:8] = data;
                        cnt_now[prt] = cnt_reload[prt];
                        write_msb_next[prt] = 1'b0;
                        cnt_running[prt] = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      w.out_zero = out_level[0];
      w.out_one  = out_level[1];
      w.out_two  = out_level[2];
      pending_rsp_words.push_back(w);
   endtask

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // entered and left at a falling edge; valid stays high on exit
   task automatic issue_word(input logic [1:0] act, input logic [1:0] prt,
                             input logic [7:0] data);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.port   <= prt;
      req_chan.wdata  <= data;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_timer_word(act, prt, data);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_rsp_drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_rsp_words.size() != 0);
   endtask

   task automatic program_counter(input logic [1:0] sel, input logic [2:0] mode,
                                  input logic [1:0] acc, input logic [15:0] value,
                                  input bit bcd);
      issue_word(ACT_WRITE, PORT_CTRL, {sel, acc, mode, bcd});
      case (acc)
         ACC_LSB: issue_word(ACT_WRITE, sel, value[7:0]);
         ACC_MSB: issue_word(ACT_WRITE, sel, value[15:8]);
         default: begin
            issue_word(ACT_WRITE, sel, value[7:0]);
            issue_word(ACT_WRITE, sel, value[15:8]);
         end
      endcase
   endtask

   task automatic run_ticks(input int k);
      repeat (k) issue_word(ACT_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
   endtask

   task automatic read_counter(input logic [1:0] sel);
      issue_word(ACT_READ, sel, 8'($urandom_range(0, 255)));
   endtask

   task automatic latch_counter(input logic [1:0] sel);
      issue_word(ACT_WRITE, PORT_CTRL, {sel, ACC_LATCH, 4'($urandom_range(0, 15))});
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_idle_ports();
      read_counter(2'd0);
      read_counter(2'd0);
      issue_word(ACT_READ, PORT_CTRL, 8'h00);
      issue_word(ACT_NOP, 2'd1, 8'hff);
      // read-back select is dropped whatever the access bits say
      issue_word(ACT_WRITE, PORT_CTRL, {SEL_READBACK, ACC_BOTH, 4'b0110});
      issue_word(ACT_WRITE, PORT_CTRL, {SEL_READBACK, ACC_LATCH, 4'b0000});
   endtask

   task automatic test_counting_modes();
      program_counter(2'd0, MODE_TERMINAL, ACC_BOTH, 16'd2, 1'b0);
      program_counter(2'd1, 3'd6, ACC_BOTH, 16'd3, 1'b0);
      program_counter(2'd2, 3'd7, ACC_LSB, 16'd5, 1'b1);
      run_ticks(6);
   endtask

   task automatic test_latch_and_access();
      latch_counter(2'd2);
      run_ticks(2);
      latch_counter(2'd2);        // already held, must not refresh
      read_counter(2'd2);
      read_counter(2'd2);
      program_counter(2'd1, 3'd1, ACC_MSB, 16'hff00, 1'b0);
      read_counter(2'd1);
      // terminal count again while OUT is still high
      program_counter(2'd0, MODE_TERMINAL, ACC_BOTH, 16'h0001, 1'b0);
      run_ticks(1);
   endtask

   task automatic test_random_traffic();
      int unsigned r;
      logic [15:0] value;
      logic [1:0]  sel;
      while (items_sent < ITEM_TARGET) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         sel = 2'($urandom_range(0, NUM_COUNTERS - 1));
         if (r < 30) begin
            case ($urandom_range(0, 9))
               0:       value = 16'($urandom_range(0, 65535));
               1, 2:    value = 16'($urandom_range(0, 300));
               default: value = 16'($urandom_range(0, 12));
            endcase
            program_counter(sel, 3'($urandom_range(0, 7)), 2'($urandom_range(1, 3)),
                            value, 1'($urandom_range(0, 1)));
         end else if (r < 55) begin
            run_ticks($urandom_range(1, 20));
         end else if (r < 65) begin
            latch_counter(sel);
            repeat ($urandom_range(1, 2)) read_counter(sel);
         end else if (r < 78) begin
            repeat ($urandom_range(1, 3)) read_counter(sel);
         end else if (r < 85) begin
            // lone data byte: breaks two-byte sequences
            issue_word(ACT_WRITE, sel, 8'($urandom_range(0, 255)));
         end else if (r < 90) begin
            issue_word(ACT_WRITE, PORT_CTRL, 8'($urandom_range(0, 255)));
         end else begin
            issue_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       8'($urandom_range(0, 255)));
         end
      end
      no_gaps = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_left == 0) begin
         rsp_pick = $urandom_range(0, 99);
         if (rsp_pick < 50) begin
            rsp_stall = 1'b0;
            rsp_left  = $urandom_range(1, 40);
         end else if (rsp_pick < 92) begin
            rsp_stall = 1'b1;
            rsp_left  = $urandom_range(1, 3);
         end else begin
            rsp_stall = 1'b1;
            rsp_left  = $urandom_range(10, 40);
         end
      end
      rsp_left--;
      rsp_chan.ready <= !rsp_stall;
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rsp_words.size() == 0) begin
            $display("%0t: unexpected response word, rdata %02h", $time, rsp_chan.rdata);
            fail_count++;
         end else begin
            oldest_word = pending_rsp_words.pop_front();
            check_field("rdata",     oldest_word.rdata,     rsp_chan.rdata);
            check_field("out_zero",  8'(oldest_word.out_zero),  8'(rsp_chan.out_zero));
            check_field("out_one",   8'(oldest_word.out_one),   8'(rsp_chan.out_one));
            check_field("out_two",   8'(oldest_word.out_two),   8'(rsp_chan.out_two));
            check_field("irq_pulse", 8'(oldest_word.irq_pulse), 8'(rsp_chan.irq_pulse));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.action = ACT_TICK;
      req_chan.port   = 2'd0;
      req_chan.wdata  = 8'h00;
      rsp_chan.ready  = 1'b0;
      for (int n = 0; n < NUM_COUNTERS; n++) begin
         cnt_now[n]        = '0;
         cnt_reload[n]     = '0;
         cnt_latched[n]    = '0;
         latch_held[n]     = 1'b0;
         cnt_mode[n]       = MODE_TERMINAL;
         acc_mode[n]       = ACC_BOTH;
         read_msb_next[n]  = 1'b0;
         write_msb_next[n] = 1'b0;
         out_level[n]      = 1'b0;
         cnt_running[n]    = 1'b0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_ports();
      test_counting_modes();
      test_latch_and_access();
      wait_rsp_drain();
      test_random_traffic();

      wait_rsp_drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
